### design/mvss_pkg.sv
// Shared types, constants and codes for the multi-voice sweep synthesiser.
// No dependencies; every other design file imports this package.
package mvss_pkg;

  localparam int VOICE_COUNT_DEF = 6;

  localparam int          TONE_LEVEL   = 11000;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;
  localparam int          HALF_SCALE   = 32768;
  localparam logic [12:0] GAIN_MAX     = 13'd4096;
  localparam logic [8:0]  MASTER_UNITY = 9'd256;
  localparam logic [8:0]  MASTER_RESET = 9'd128;
  localparam int          DIV3_RECIP   = 43691;  // ceil(2^17 / 3)
  localparam int          CMD_DEPTH    = 2;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  typedef enum logic [1:0] {
    WAVE_SQUARE = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SINE   = 2'd2,
    WAVE_NOISE  = 2'd3
  } wave_t;

  typedef struct packed {
    logic        op;
    wave_t       wave;
    logic [15:0] start_step;
    logic [15:0] end_step;
    logic [12:0] gain;
    logic [15:0] attack;
    logic [15:0] length;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_if_t;

  typedef struct packed {
    logic        go;
    logic [31:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

endpackage

### design/mvss_front.sv
// Front end: takes input transfers, clamps the gain and queues commands.
// Depends on mvss_pkg.
module mvss_front
  import mvss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [1:0]  waveform,
  input  logic [15:0] start_step,
  input  logic [15:0] end_step,
  input  logic [12:0] amplitude,
  input  logic [15:0] attack_samples,
  input  logic [15:0] duration_samples,
  output cmd_if_t     cmd_out,
  input  logic        cmd_pop
);

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t               slots [CMD_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [PTR_W:0]     count;
  cmd_t               incoming;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    incoming.op         = operation;
    incoming.wave       = wave_t'(waveform);
    incoming.start_step = start_step;
    incoming.end_step   = end_step;
    incoming.gain       = (amplitude > GAIN_MAX) ? GAIN_MAX : amplitude;
    incoming.attack     = attack_samples;
    incoming.length     = duration_samples;
  end

  assign full          = (count == (PTR_W+1)'(CMD_DEPTH));
  assign do_push       = push && !full;
  assign do_pop        = cmd_pop && (count != '0);
  assign cmd_out.valid = (count != '0);
  assign cmd_out.cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + PTR_W'(1);
      if (do_pop)  rptr <= rptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

### design/mvss_div.sv
// Serial restoring divider, one quotient bit per cycle, 16-bit quotient.
// Caller guarantees num[31:16] < den. Depends on mvss_pkg.
module mvss_div
  import mvss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [15:0] rem;
  logic [15:0] shreg;
  logic [15:0] den;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic        qbit;

  assign trial = {rem, shreg[15]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem   <= req.num[31:16];
      shreg <= req.num[15:0];
      den   <= req.den;
    end else if (busy) begin
      rem   <= qbit ? 16'(trial - {1'b0, den}) : trial[15:0];
      shreg <= {shreg[14:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = shreg;

endmodule

### design/mvss_engine.sv
// Back end: voice store, trigger allocation and the per-voice tick sequencer.
// Depends on mvss_pkg and mvss_div.
module mvss_engine
  import mvss_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_if_t            cmd_in,
  output logic               cmd_pop,
  input  logic [8:0]         master,
  input  logic               out_full,
  output logic               res_push,
  output logic signed [15:0] res_sample
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int MIX_W = 16 + $clog2(VOICE_COUNT);
  localparam int SCL_W = MIX_W + 10;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(VOICE_COUNT - 1);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_PICK_MUL = 14'b00000000000010,
    ST_PICK_CMP = 14'b00000000000100,
    ST_LOAD     = 14'b00000000001000,
    ST_V_START  = 14'b00000000010000,
    ST_V_DIV1   = 14'b00000000100000,
    ST_V_DIV2   = 14'b00000001000000,
    ST_V_WAVE1  = 14'b00000010000000,
    ST_V_WAVE2  = 14'b00000100000000,
    ST_V_GAIN   = 14'b00001000000000,
    ST_V_ENV    = 14'b00010000000000,
    ST_V_ACC    = 14'b00100000000000,
    ST_SCALE    = 14'b01000000000000,
    ST_OUT      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [VOICE_COUNT-1:0] v_active;
  wave_t                  v_wave  [VOICE_COUNT];
  logic [15:0]            v_start [VOICE_COUNT];
  logic [15:0]            v_end   [VOICE_COUNT];
  logic [12:0]            v_gain  [VOICE_COUNT];
  logic [15:0]            v_att   [VOICE_COUNT];
  logic [15:0]            v_len   [VOICE_COUNT];
  logic [15:0]            v_el    [VOICE_COUNT];
  logic [15:0]            v_phase [VOICE_COUNT];

  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   best;
  logic [15:0]        best_el;
  logic [15:0]        best_len;
  logic [31:0]        prod_l;
  logic [31:0]        prod_r;
  cmd_t               cmd_r;
  logic [15:0]        el_r;
  logic               dneg;
  logic               env_dec;
  logic [16:0]        env_r;
  logic [15:0]        ph_r;
  logic signed [16:0] opa;
  logic signed [14:0] w_r;
  logic signed [27:0] wg_r;
  logic signed [44:0] c_r;
  logic signed [MIX_W-1:0] mix;
  logic signed [SCL_W-1:0] scaled;
  logic [15:0]        noise;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        div_go;
  logic [31:0] div_num;
  logic [15:0] div_den;

  assign div_req.go  = div_go;
  assign div_req.num = div_num;
  assign div_req.den = div_den;

  mvss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // lowest-index free voice
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!v_active[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // tick start-of-voice values
  logic [16:0] el17;
  logic [15:0] mag;
  logic        end_lt;
  assign el17   = {1'b0, v_el[idx]} + 17'd1;
  assign end_lt = (v_end[idx] < v_start[idx]);
  assign mag    = end_lt ? (v_start[idx] - v_end[idx]) : (v_end[idx] - v_start[idx]);

  logic [15:0] phase_new;
  assign phase_new = v_phase[idx] + v_start[idx] +
                     (dneg ? (16'd0 - div_rsp.quo) : div_rsp.quo);

  logic [15:0] el_m_att;
  assign el_m_att = el_r - v_att[idx];

  // first wave stage
  logic [14:0] tph;
  logic [30:0] sine_p;
  logic [16:0] sine_y;
  logic [15:0] lfsr_nx;
  assign tph     = ph_r[14:0];
  assign sine_p  = 31'(tph) * 31'(17'd32768 - {2'b0, tph});
  assign sine_y  = {2'b0, sine_p[28:14]};
  assign lfsr_nx = noise[0] ? ({1'b0, noise[15:1]} ^ LFSR_TAPS) : {1'b0, noise[15:1]};

  // second wave stage
  logic signed [31:0] p11;
  logic [16:0]        opa_mag;
  logic [33:0]        p3;
  logic [15:0]        q3;
  logic signed [14:0] w_val;
  assign p11     = 32'(opa) * 32'(TONE_LEVEL);
  assign opa_mag = opa[16] ? 17'(-opa) : 17'(opa);
  assign p3      = 34'(opa_mag) * 34'(DIV3_RECIP);
  assign q3      = p3[32:17];

  always_comb begin
    case (cmd_r.wave == WAVE_SQUARE ? WAVE_SQUARE : v_wave[idx])
      WAVE_SQUARE: w_val = ph_r[15] ? 15'(TONE_LEVEL) : -15'(TONE_LEVEL);
      WAVE_SAW:    w_val = 15'(p11 >>> 15);
      WAVE_SINE:   w_val = 15'(p11 >>> 14);
      default:     w_val = opa[16] ? -$signed(15'(q3)) : $signed(15'(q3));
    endcase
  end

  // contribution truncated toward zero
  logic signed [44:0] c_bias;
  logic signed [15:0] contrib;
  assign c_bias  = c_r + (c_r[44] ? 45'sd134217727 : 45'sd0);
  assign contrib = 16'(c_bias >>> 27);

  logic [8:0]              mv;
  logic signed [SCL_W-1:0] s_bias;
  logic signed [SCL_W-1:0] s_div;
  assign mv     = (master > MASTER_UNITY) ? MASTER_UNITY : master;
  assign s_bias = scaled + (scaled[SCL_W-1] ? SCL_W'(255) : SCL_W'(0));
  assign s_div  = s_bias >>> 8;

  always_comb begin
    if (s_div > SCL_W'(32767))        res_sample = 16'sh7FFF;
    else if (s_div < -SCL_W'(32768))  res_sample = 16'sh8000;
    else                              res_sample = 16'(s_div);
  end

  assign cmd_pop  = (state == ST_IDLE) && cmd_in.valid;
  assign res_push = (state == ST_OUT) && !out_full;

  // voice store writes
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      v_wave[best]  <= cmd_r.wave;
      v_start[best] <= cmd_r.start_step;
      v_end[best]   <= cmd_r.end_step;
      v_gain[best]  <= cmd_r.gain;
      v_att[best]   <= cmd_r.attack;
      v_len[best]   <= cmd_r.length;
      v_el[best]    <= '0;
      v_phase[best] <= '0;
    end else if (state == ST_V_START && v_active[idx]) begin
      v_el[idx] <= el17[15:0];
    end else if (state == ST_V_DIV1 && div_rsp.done) begin
      v_phase[idx] <= phase_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd_r    <= cmd_in.cmd;
        idx      <= (cmd_in.cmd.op == OP_TRIGGER && VOICE_COUNT > 1) ? IDX_W'(1) : '0;
        best     <= free_any ? free_idx : '0;
        best_el  <= v_el[0];
        best_len <= v_len[0];
        mix      <= '0;
      end
      ST_PICK_MUL: begin
        prod_l <= 32'(v_el[idx]) * 32'(best_len);
        prod_r <= 32'(best_el) * 32'(v_len[idx]);
      end
      ST_PICK_CMP: begin
        if (prod_l > prod_r) begin
          best     <= idx;
          best_el  <= v_el[idx];
          best_len <= v_len[idx];
        end
        if (idx != LAST) idx <= idx + IDX_W'(1);
      end
      ST_V_START: begin
        el_r    <= el17[15:0];
        dneg    <= end_lt;
        div_num <= 32'(mag) * 32'(el17[15:0]);
        div_den <= v_len[idx];
        if (!v_active[idx] || el17 >= {1'b0, v_len[idx]}) begin
          if (idx != LAST) idx <= idx + IDX_W'(1);
        end
      end
      ST_V_DIV1: begin
        ph_r <= phase_new;
        if (el_r < v_att[idx]) begin
          div_num <= {1'b0, el_r, 15'b0};
          div_den <= v_att[idx];
          env_dec <= 1'b0;
        end else begin
          div_num <= {1'b0, el_m_att, 15'b0};
          div_den <= v_len[idx] - v_att[idx];
          env_dec <= 1'b1;
        end
      end
      ST_V_DIV2: begin
        env_r <= env_dec ? (17'd32768 - {1'b0, div_rsp.quo}) : {1'b0, div_rsp.quo};
        cmd_r.wave <= v_wave[idx];
      end
      ST_V_WAVE1: begin
        case (v_wave[idx])
          WAVE_SAW:   opa <= $signed({1'b0, ph_r}) - 17'sd32768;
          WAVE_SINE:  opa <= ph_r[15] ? -$signed(sine_y) : $signed(sine_y);
          WAVE_NOISE: opa <= $signed({1'b0, lfsr_nx}) - 17'sd32768;
          default:    opa <= '0;
        endcase
      end
      ST_V_WAVE2: w_r  <= w_val;
      ST_V_GAIN:  wg_r <= 28'(w_r) * 28'($signed({1'b0, v_gain[idx]}));
      ST_V_ENV:   c_r  <= 45'(wg_r) * 45'($signed({1'b0, env_r}));
      ST_V_ACC: begin
        mix <= mix + MIX_W'(contrib);
        if (idx != LAST) idx <= idx + IDX_W'(1);
      end
      ST_SCALE:   scaled <= SCL_W'(mix) * SCL_W'($signed({1'b0, mv}));
      ST_LOAD, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      v_active <= '0;
      noise    <= LFSR_SEED;
      div_go   <= 1'b0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_in.valid) begin
            if (cmd_in.cmd.op == OP_TICK)                   state <= ST_V_START;
            else if (free_any || VOICE_COUNT == 1)          state <= ST_LOAD;
            else                                            state <= ST_PICK_MUL;
          end
        end
        ST_PICK_MUL: state <= ST_PICK_CMP;
        ST_PICK_CMP: state <= (idx == LAST) ? ST_LOAD : ST_PICK_MUL;
        ST_LOAD: begin
          v_active[best] <= 1'b1;
          state          <= ST_IDLE;
        end
        ST_V_START: begin
          if (!v_active[idx]) begin
            state <= (idx == LAST) ? ST_SCALE : ST_V_START;
          end else if (el17 >= {1'b0, v_len[idx]}) begin
            v_active[idx] <= 1'b0;
            state         <= (idx == LAST) ? ST_SCALE : ST_V_START;
          end else begin
            div_go <= 1'b1;
            state  <= ST_V_DIV1;
          end
        end
        ST_V_DIV1: begin
          if (div_rsp.done) begin
            div_go <= 1'b1;
            state  <= ST_V_DIV2;
          end
        end
        ST_V_DIV2:  if (div_rsp.done) state <= ST_V_WAVE1;
        ST_V_WAVE1: begin
          if (v_wave[idx] == WAVE_NOISE) noise <= lfsr_nx;
          state <= ST_V_WAVE2;
        end
        ST_V_WAVE2: state <= ST_V_GAIN;
        ST_V_GAIN:  state <= ST_V_ENV;
        ST_V_ENV:   state <= ST_V_ACC;
        ST_V_ACC:   state <= (idx == LAST) ? ST_SCALE : ST_V_START;
        ST_SCALE:   state <= ST_OUT;
        ST_OUT:     if (!out_full) state <= ST_IDLE;
        default:    state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full) else $error("result pushed into occupied output slot");

  a_div_not_instant: assert property (@(posedge clk) disable iff (rst)
    div_req.go |=> !div_rsp.done) else $error("divider finished on its start cycle");

  a_load_activates: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> v_active[$past(best)]) else $error("loaded voice not active");
`endif

endmodule

### design/multi_voice_sweep_synth_unit.sv
// Top level of the multi-voice sweep synthesiser: master volume register,
// output slot and the front/back split. Depends on mvss_pkg, mvss_front, mvss_engine.
//
//  channel   signals                                  dir   transfer when
//  input     push, full, operation .. duration_samples  in   push && !full
//  result    empty, pop, sample                        out   pop && !empty
//  config    cfg_valid, cfg_ready, cfg_data            in   cfg_valid && cfg_ready
//
// A trigger with a free voice loads it directly, else a cross-multiply search over the
// voices picks one. A tick skips idle voices and runs each sounding voice through two
// passes of the serial divider, each giving a 16-bit quotient.
// Synchronous reset clears all voices and loads the noise seed and master volume.
// A two-entry command queue absorbs input; the engine stalls only on a full output slot.
module multi_voice_sweep_synth_unit
  import mvss_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [1:0]         waveform,
  input  logic [15:0]        start_step,
  input  logic [15:0]        end_step,
  input  logic [12:0]        amplitude,
  input  logic [15:0]        attack_samples,
  input  logic [15:0]        duration_samples,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data
);

  logic [8:0]         master_volume;
  logic               out_valid;
  cmd_if_t            cmd_if;
  logic               cmd_pop;
  logic               res_push;
  logic signed [15:0] res_sample;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  mvss_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .operation        (operation),
    .waveform         (waveform),
    .start_step       (start_step),
    .end_step         (end_step),
    .amplitude        (amplitude),
    .attack_samples   (attack_samples),
    .duration_samples (duration_samples),
    .cmd_out          (cmd_if),
    .cmd_pop          (cmd_pop)
  );

  mvss_engine #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (cmd_if),
    .cmd_pop    (cmd_pop),
    .master     (master_volume),
    .out_full   (out_valid),
    .res_push   (res_push),
    .res_sample (res_sample)
  );

  always_ff @(posedge clk) begin
    if (res_push) sample <= res_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= MASTER_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) master_volume <= cfg_data;
      if (res_push)               out_valid <= 1'b1;
      else if (pop && out_valid)  out_valid <= 1'b0;
    end
  end

endmodule
